/* hw/rtl/spq_pkg.sv */
package spq_pkg;

  localparam int KeyW = 16;
  localparam int PriW = 16;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_ENQ   = 2'd0;
  localparam kind_t KIND_DEQ   = 2'd1;
  localparam kind_t KIND_UPD   = 2'd2;
  localparam kind_t KIND_CLEAR = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_EMPTY   = 2'd1;
  localparam status_t ST_FULL    = 2'd2;
  localparam status_t ST_MISSING = 2'd3;

  typedef struct packed {
    logic [PriW-1:0] pri;
    logic [KeyW-1:0] key;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SCAN,
    S_INS_FRONT,
    S_INS_START,
    S_POP,
    S_SHIFT,
    S_FIND,
    S_DONE
  } state_t;

endpackage

/* hw/rtl/spq_ram.sv */
module spq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/sorted_priority_queue.sv */
// sorted priority queue kept as an ordered list in one synchronous ram
// one transaction at a time; what each kind does:
//   clear, full, empty: straight to the result; enqueue: walk from the back, moving entries behind the new one
//   dequeue: pop the front and pull the rest forward; update: scan to the key, shift the tail, then an enqueue
// each walk step reads one ram entry, and insert and shift steps also write one back
// rst (synchronous, active high) empties the queue and drops any pending result
module sorted_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // key [15:0], priority_req [31:16]
  input  logic [1:0]  s_tuser,   // kind [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // out_key [15:0]
  output logic [1:0]  m_tuser    // status [1:0]
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  spq_pkg::state_t  state, state_next;
  logic [AW-1:0]    idx, idx_next;
  logic [CW-1:0]    cnt, cnt_next;
  spq_pkg::kind_t   op, op_next;
  spq_pkg::entry_t  item, item_next;
  spq_pkg::status_t res_status, res_status_next;
  logic [15:0]      res_key, res_key_next;
  logic             m_valid_next;
  logic [15:0]      m_key_next;
  spq_pkg::status_t m_status_next;

  // ram port signals
  logic             we;
  logic [AW-1:0]    waddr;
  spq_pkg::entry_t  wdata;
  logic [AW-1:0]    raddr;
  spq_pkg::entry_t  rdata;

  logic [CW-1:0]    cnt_m1;
  logic             at_last;

  assign cnt_m1  = cnt - CW'(1);
  // current index is the last valid entry
  assign at_last = ({{(CW-AW){1'b0}}, idx} == cnt_m1);

  spq_ram #(
    .WIDTH ($bits(spq_pkg::entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign s_tready = (state == spq_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= spq_pkg::S_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      m_tvalid <= m_valid_next;
    end
    idx        <= idx_next;
    op         <= op_next;
    item       <= item_next;
    res_status <= res_status_next;
    res_key    <= res_key_next;
    m_tdata    <= m_key_next;
    m_tuser    <= m_status_next;
  end

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    cnt_next        = cnt;
    op_next         = op;
    item_next       = item;
    res_status_next = res_status;
    res_key_next    = res_key;
    m_valid_next    = m_tvalid && !m_tready;
    m_key_next      = m_tdata;
    m_status_next   = m_tuser;
    we              = 1'b0;
    waddr           = idx;
    wdata           = rdata;
    raddr           = idx;

    case (state)
      spq_pkg::S_IDLE: begin
        if (s_tvalid) begin
          op_next         = s_tuser;
          item_next.key   = s_tdata[15:0];
          item_next.pri   = s_tdata[31:16];
          res_status_next = spq_pkg::ST_OK;
          res_key_next    = '0;
          state_next      = spq_pkg::S_DONE;
          case (s_tuser)
            spq_pkg::KIND_ENQ: begin
              if (cnt == CW'(DEPTH)) begin
                res_status_next = spq_pkg::ST_FULL;
              end else begin
                state_next = spq_pkg::S_INS_START;
              end
            end
            spq_pkg::KIND_DEQ: begin
              if (cnt == '0) begin
                res_status_next = spq_pkg::ST_EMPTY;
              end else begin
                raddr      = '0;
                idx_next   = '0;
                state_next = spq_pkg::S_POP;
              end
            end
            spq_pkg::KIND_UPD: begin
              if (cnt == '0) begin
                res_status_next = spq_pkg::ST_MISSING;
              end else begin
                raddr      = '0;
                idx_next   = '0;
                state_next = spq_pkg::S_FIND;
              end
            end
            default: begin
              cnt_next = '0;
            end
          endcase
        end
      end

      // begin an insert walk from the back of the list, or write entry 0 directly into an empty queue
      spq_pkg::S_INS_START: begin
        if (cnt == '0) begin
          we         = 1'b1;
          waddr      = '0;
          wdata      = item;
          cnt_next   = CW'(1);
          state_next = spq_pkg::S_DONE;
        end else begin
          raddr      = cnt_m1[AW-1:0];
          idx_next   = cnt_m1[AW-1:0];
          state_next = spq_pkg::S_INS_SCAN;
        end
      end

      // rdata is entry idx; move it back if the new one goes ahead of it, else put the new one behind it
      spq_pkg::S_INS_SCAN: begin
        we    = 1'b1;
        waddr = idx + AW'(1);
        if (item.pri >= rdata.pri) begin
          wdata = rdata;
          if (idx == '0) begin
            state_next = spq_pkg::S_INS_FRONT;
          end else begin
            raddr    = idx - AW'(1);
            idx_next = idx - AW'(1);
          end
        end else begin
          wdata      = item;
          cnt_next   = cnt + CW'(1);
          state_next = spq_pkg::S_DONE;
        end
      end

      spq_pkg::S_INS_FRONT: begin
        we         = 1'b1;
        waddr      = '0;
        wdata      = item;
        cnt_next   = cnt + CW'(1);
        state_next = spq_pkg::S_DONE;
      end

      spq_pkg::S_POP: begin
        res_key_next = rdata.key;
        if (cnt == CW'(1)) begin
          cnt_next   = '0;
          state_next = spq_pkg::S_DONE;
        end else begin
          raddr      = AW'(1);
          idx_next   = AW'(1);
          state_next = spq_pkg::S_SHIFT;
        end
      end

      // rdata is entry idx; pull it forward by one
      spq_pkg::S_SHIFT: begin
        we    = 1'b1;
        waddr = idx - AW'(1);
        wdata = rdata;
        if (at_last) begin
          cnt_next   = cnt_m1;
          state_next = (op == spq_pkg::KIND_UPD) ? spq_pkg::S_INS_START : spq_pkg::S_DONE;
        end else begin
          raddr    = idx + AW'(1);
          idx_next = idx + AW'(1);
        end
      end

      spq_pkg::S_FIND: begin
        if (rdata.key == item.key) begin
          if (at_last) begin
            cnt_next   = cnt_m1;
            state_next = spq_pkg::S_INS_START;
          end else begin
            raddr      = idx + AW'(1);
            idx_next   = idx + AW'(1);
            state_next = spq_pkg::S_SHIFT;
          end
        end else if (at_last) begin
          res_status_next = spq_pkg::ST_MISSING;
          state_next      = spq_pkg::S_DONE;
        end else begin
          raddr    = idx + AW'(1);
          idx_next = idx + AW'(1);
        end
      end

      // hand the result to the output register once it is free
      spq_pkg::S_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_valid_next  = 1'b1;
          m_key_next    = res_key;
          m_status_next = res_status;
          state_next    = spq_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = spq_pkg::S_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= CW'(DEPTH))
    else $error("entry count above depth");

  a_empty_key: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && (m_tuser != spq_pkg::ST_OK) |-> m_tdata == '0)
    else $error("nonzero key with error status");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
      (state == spq_pkg::S_IDLE) || (state == spq_pkg::S_DONE) |-> !we)
    else $error("ram write outside an operation");

  a_cnt_stable_done: assert property (@(posedge clk) disable iff (rst)
      (state == spq_pkg::S_DONE) |=> $stable(cnt))
    else $error("count changed while holding a result");
`endif

endmodule
